### hw/rtl/cfse_pkg.sv
// Shared types, constants and helpers for the CAN frame stack ASCII encoder.
// No dependencies.
package cfse_pkg;

   localparam int QueueDepth     = 16;
   localparam int StackAddrWidth = $clog2(QueueDepth);
   localparam int FifoDepth      = 2;
   localparam int FifoPtrWidth   = $clog2(FifoDepth);
   localparam int FifoCountWidth = $clog2(FifoDepth + 1);

   localparam logic [StackAddrWidth-1:0] StackOne  = StackAddrWidth'(1);
   localparam logic [StackAddrWidth-1:0] StackLast = StackAddrWidth'(QueueDepth - 1);

   localparam logic OpPush  = 1'b0;
   localparam logic OpDrain = 1'b1;

   localparam logic [3:0] MaxDataBytes = 4'd8;
   localparam logic [3:0] ExtIdDigits  = 4'd7;
   localparam logic [3:0] StdIdDigits  = 4'd2;

   localparam logic [7:0] CharCr      = 8'h0D;
   localparam logic [7:0] CharExtData = 8'h54;
   localparam logic [7:0] CharExtRtr  = 8'h52;
   localparam logic [7:0] CharStdData = 8'h74;
   localparam logic [7:0] CharStdRtr  = 8'h72;

   typedef struct packed {
      logic        ext;
      logic        rtr;
      logic [28:0] id;
      logic [3:0]  dlc;
      logic [63:0] payload;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic one_free;
   } fifo_stat_type;

   typedef enum logic [2:0] {
      ENC_IDLE,
      ENC_TYPE,
      ENC_ID,
      ENC_DLC,
      ENC_DATA,
      ENC_CR
   } enc_state_type;

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'b0000, nib};
      return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
   endfunction

endpackage

### hw/rtl/can_frame_stack_ascii_encoder_core.sv
// A push stores the frame on a last-in-first-out stack of QueueDepth slots
// (at most QueueDepth-1 frames; a push onto a full stack is dropped). A drain
// pops the newest frame at once; the character serialiser then emits its
// SLCAN line one character a cycle, 6+2n characters for a standard frame or
// 11+2n for an extended one (n data bytes, none for remote frames); the first
// comes after the popped frame passes the pop register and the queue while the
// serialiser is idle. The serialiser goes back to idle between lines, so
// consecutive lines always have an idle gap between them. Up to two popped
// frames wait in a queue ahead of the serialiser; busy is high while that
// queue is full, or holds one frame with another pop on its way into it.
// A drain on an empty stack emits nothing.
// Results are strobed by rsp_valid for one cycle and cannot be held off.
// Top level: instantiates cfse_front, cfse_fifo and cfse_back; uses cfse_pkg.
module can_frame_stack_ascii_encoder_core
   import cfse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic        req_extended_id,
   input  logic        req_remote_request,
   input  logic [28:0] req_frame_id,
   input  logic [3:0]  req_byte_count,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   output logic [7:0]  rsp_ascii_char,
   output logic        rsp_last_char
);

   fifo_stat_type fifo_stat;
   logic          fifo_wr;
   logic          fifo_rd;
   frame_type     fifo_wr_data;
   frame_type     fifo_rd_data;

   cfse_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_extended_id    (req_extended_id),
      .req_remote_request (req_remote_request),
      .req_frame_id       (req_frame_id),
      .req_byte_count     (req_byte_count),
      .req_payload        (req_payload),
      .fifo_stat          (fifo_stat),
      .fifo_wr            (fifo_wr),
      .fifo_wr_data       (fifo_wr_data)
   );

   cfse_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr      (fifo_wr),
      .wr_data (fifo_wr_data),
      .rd      (fifo_rd),
      .rd_data (fifo_rd_data),
      .stat    (fifo_stat)
   );

   cfse_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_stat      (fifo_stat),
      .fifo_rd_data   (fifo_rd_data),
      .fifo_rd        (fifo_rd),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

`ifndef ASSERT_OFF
   a_last_is_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_ascii_char == CharCr)
      else $error("end mark on a character other than carriage return");

   a_gap_after_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |=> !rsp_valid)
      else $error("character emitted right after end of line");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_wr |-> !fifo_stat.full)
      else $error("popped frame written into a full queue");
`endif

endmodule

### hw/rtl/cfse_front.sv
// Front end: command decode, frame stack memory and pop read-out.
// Depends on cfse_pkg.
module cfse_front
   import cfse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic          req_operation,
   input  logic          req_extended_id,
   input  logic          req_remote_request,
   input  logic [28:0]   req_frame_id,
   input  logic [3:0]    req_byte_count,
   input  logic [63:0]   req_payload,
   input  fifo_stat_type fifo_stat,
   output logic          fifo_wr,
   output frame_type     fifo_wr_data
);

   frame_type                 stack_mem [QueueDepth];
   frame_type                 rd_data_ff;
   logic                      rd_valid_ff, rd_valid_in;
   logic [StackAddrWidth-1:0] count_ff, count_in;
   logic                      accept, do_push, do_pop;
   frame_type                 wr_frame;

   assign busy    = fifo_stat.full || (rd_valid_ff && fifo_stat.one_free);
   assign accept  = start && !busy;
   assign do_push = accept && (req_operation == OpPush) && (count_ff != StackLast);
   assign do_pop  = accept && (req_operation == OpDrain) && (count_ff != '0);

   always_comb begin
      wr_frame.ext     = req_extended_id;
      wr_frame.rtr     = req_remote_request;
      wr_frame.id      = req_frame_id;
      wr_frame.dlc     = req_byte_count;
      wr_frame.payload = req_payload;
      count_in         = count_ff;
      if (do_push) begin
         count_in = count_ff + StackOne;
      end else if (do_pop) begin
         count_in = count_ff - StackOne;
      end
      rd_valid_in = do_pop;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_mem[count_ff] <= wr_frame;
      end
      if (do_pop) begin
         rd_data_ff <= stack_mem[count_ff - StackOne];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign fifo_wr      = rd_valid_ff;
   assign fifo_wr_data = rd_data_ff;

endmodule

### hw/rtl/cfse_fifo.sv
// Short queue of popped frames between front and back ends.
// Depends on cfse_pkg.
module cfse_fifo
   import cfse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          wr,
   input  frame_type     wr_data,
   input  logic          rd,
   output frame_type     rd_data,
   output fifo_stat_type stat
);

   frame_type                 entry_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCountWidth-1:0] count_ff, count_in;
   logic                      do_wr, do_rd;

   assign do_wr = wr && !stat.full;
   assign do_rd = rd && !stat.empty;

   assign stat.full     = (count_ff == FifoCountWidth'(FifoDepth));
   assign stat.empty    = (count_ff == '0);
   assign stat.one_free = (count_ff == FifoCountWidth'(FifoDepth - 1));
   assign rd_data       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == FifoPtrWidth'(FifoDepth - 1)) ? '0
                     : wr_ptr_ff + FifoPtrWidth'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == FifoPtrWidth'(FifoDepth - 1)) ? '0
                     : rd_ptr_ff + FifoPtrWidth'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + FifoCountWidth'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - FifoCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/cfse_back.sv
// Back end: serialises one frame into an SLCAN ASCII line, one character a cycle.
// Depends on cfse_pkg.
module cfse_back
   import cfse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  fifo_stat_type fifo_stat,
   input  frame_type     fifo_rd_data,
   output logic          fifo_rd,
   output logic          rsp_valid,
   output logic [7:0]    rsp_ascii_char,
   output logic          rsp_last_char
);

   enc_state_type state_ff, state_in;
   logic [31:0]   id_ff, id_in;
   logic [63:0]   data_ff, data_in;
   logic [3:0]    dlc_ff, dlc_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          half_ff, half_in;
   logic          ext_ff, ext_in;
   logic          rtr_ff, rtr_in;
   logic          valid_ff, valid_in;
   logic [7:0]    char_ff, char_in;
   logic          last_ff, last_in;

   always_comb begin
      state_in = state_ff;
      id_in    = id_ff;
      data_in  = data_ff;
      dlc_in   = dlc_ff;
      cnt_in   = cnt_ff;
      half_in  = half_ff;
      ext_in   = ext_ff;
      rtr_in   = rtr_ff;
      valid_in = 1'b0;
      char_in  = char_ff;
      last_in  = 1'b0;
      fifo_rd  = 1'b0;
      unique case (state_ff)
         ENC_IDLE: begin
            if (!fifo_stat.empty) begin
               fifo_rd  = 1'b1;
               ext_in   = fifo_rd_data.ext;
               rtr_in   = fifo_rd_data.rtr;
               id_in    = fifo_rd_data.ext ? {3'b000, fifo_rd_data.id}
                          : {1'b0, fifo_rd_data.id[10:0], 20'd0};
               dlc_in   = (fifo_rd_data.dlc > MaxDataBytes) ? MaxDataBytes
                          : fifo_rd_data.dlc;
               data_in  = fifo_rd_data.payload;
               state_in = ENC_TYPE;
            end
         end
         ENC_TYPE: begin
            valid_in = 1'b1;
            if (ext_ff) begin
               char_in = rtr_ff ? CharExtRtr : CharExtData;
               cnt_in  = ExtIdDigits;
            end else begin
               char_in = rtr_ff ? CharStdRtr : CharStdData;
               cnt_in  = StdIdDigits;
            end
            state_in = ENC_ID;
         end
         ENC_ID: begin
            valid_in = 1'b1;
            char_in  = hex_char(id_ff[31:28]);
            id_in    = {id_ff[27:0], 4'd0};
            if (cnt_ff == '0) begin
               state_in = ENC_DLC;
            end else begin
               cnt_in = cnt_ff - 4'd1;
            end
         end
         ENC_DLC: begin
            valid_in = 1'b1;
            char_in  = hex_char(dlc_ff);
            half_in  = 1'b0;
            if (rtr_ff || (dlc_ff == '0)) begin
               state_in = ENC_CR;
            end else begin
               cnt_in   = dlc_ff - 4'd1;
               state_in = ENC_DATA;
            end
         end
         ENC_DATA: begin
            valid_in = 1'b1;
            char_in  = hex_char(half_ff ? data_ff[3:0] : data_ff[7:4]);
            half_in  = !half_ff;
            if (half_ff) begin
               data_in = {8'd0, data_ff[63:8]};
               if (cnt_ff == '0) begin
                  state_in = ENC_CR;
               end else begin
                  cnt_in = cnt_ff - 4'd1;
               end
            end
         end
         ENC_CR: begin
            valid_in = 1'b1;
            char_in  = CharCr;
            last_in  = 1'b1;
            state_in = ENC_IDLE;
         end
         default: begin
            state_in = ENC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      data_ff <= data_in;
      dlc_ff  <= dlc_in;
      cnt_ff  <= cnt_in;
      half_ff <= half_in;
      ext_ff  <= ext_in;
      rtr_ff  <= rtr_in;
      char_ff <= char_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENC_IDLE;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last_char  = last_ff;

endmodule
